// ===== hdl/dvtu_pkg.sv =====
`timescale 1ns / 1ps
package dvtu_pkg;

   localparam int MAX_NODES = 16;
   localparam int ROW_W     = $clog2(MAX_NODES);
   localparam int COUNT_W   = $clog2(MAX_NODES + 1);
   localparam int NODE_W    = 4;
   localparam int COST_W    = 8;
   localparam int TTL_W     = 16;
   localparam int MASK_W    = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // action codes
   localparam logic [1:0] ACT_ADV  = 2'd0;
   localparam logic [1:0] ACT_TICK = 2'd1;
   localparam logic [1:0] ACT_READ = 2'd2;
   localparam logic [1:0] ACT_INIT = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SELF_NODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NODE_COUNT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NEIGHBOR_MASK = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_COST      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_TTL_RELOAD    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TICK_PERIOD   = 3'd5;

   typedef struct packed {
      logic [1:0]        action;
      logic [NODE_W-1:0] node;
      logic [COST_W-1:0] adv_cost;
      logic              last;
   } req_type;

   typedef struct packed {
      logic              status;
      logic              changed;
      logic [NODE_W-1:0] sender;
      logic              hop_valid;
      logic [NODE_W-1:0] hop_node;
      logic [COST_W-1:0] route_cost;
      logic [TTL_W-1:0]  route_ttl;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0]  self_node;
      logic [COUNT_W-1:0] eff_count;
      logic [MASK_W-1:0]  neighbor_mask;
      logic [COST_W-1:0]  max_cost;
      logic [TTL_W-1:0]   ttl_reload;
      logic [TTL_W-1:0]   tick_period;
   } cfg_type;

   typedef enum logic [1:0] {
      WALK_INIT,
      WALK_TICK,
      WALK_VEC
   } walk_op_type;

   typedef struct packed {
      logic             accept;
      logic             step_en;
      logic [ROW_W-1:0] step_idx;
      walk_op_type      step_op;
      logic             finish;
   } cmd_type;

   typedef struct packed {
      logic vec_go;
   } stat_type;

   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] idx;
   } hop_type;

endpackage

// ===== hdl/dvtu_csr.sv =====
`timescale 1ns / 1ps
module dvtu_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dvtu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dvtu_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output dvtu_pkg::cfg_type                cfg
);
   import dvtu_pkg::*;

   logic [NODE_W-1:0]  self_node_ff;
   logic [COUNT_W-1:0] node_count_ff;
   logic [MASK_W-1:0]  neighbor_mask_ff;
   logic [COST_W-1:0]  max_cost_ff;
   logic [TTL_W-1:0]   ttl_reload_ff;
   logic [TTL_W-1:0]   tick_period_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         self_node_ff     <= '0;
         node_count_ff    <= COUNT_W'(16);
         neighbor_mask_ff <= '0;
         max_cost_ff      <= COST_W'(16);
         ttl_reload_ff    <= TTL_W'(90);
         tick_period_ff   <= TTL_W'(30);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SELF_NODE:     self_node_ff     <= csr_wdata[NODE_W-1:0];
            REG_NODE_COUNT:    node_count_ff    <= csr_wdata[COUNT_W-1:0];
            REG_NEIGHBOR_MASK: neighbor_mask_ff <= csr_wdata[MASK_W-1:0];
            REG_MAX_COST:      max_cost_ff      <= csr_wdata[COST_W-1:0];
            REG_TTL_RELOAD:    ttl_reload_ff    <= csr_wdata[TTL_W-1:0];
            REG_TICK_PERIOD:   tick_period_ff   <= csr_wdata[TTL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.self_node     = self_node_ff;
      // rows in use, clipped to the table depth
      cfg.eff_count     = (node_count_ff > COUNT_W'(MAX_NODES)) ?
                          COUNT_W'(MAX_NODES) : node_count_ff;
      cfg.neighbor_mask = neighbor_mask_ff;
      cfg.max_cost      = max_cost_ff;
      cfg.ttl_reload    = ttl_reload_ff;
      cfg.tick_period   = tick_period_ff;
   end

endmodule

// ===== hdl/dvtu_ctrl.sv =====
`timescale 1ns / 1ps
module dvtu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  dvtu_pkg::req_type  req_data,
   input  dvtu_pkg::stat_type stat,
   output logic               busy,
   output dvtu_pkg::cmd_type  cmd
);
   import dvtu_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DRAIN
   } state_type;

   state_type        state_ff;
   logic [ROW_W-1:0] cnt_ff;
   walk_op_type      op_ff;
   logic             accept;
   logic             go;
   walk_op_type      go_op;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      go    = 1'b0;
      go_op = WALK_VEC;
      unique case (req_data.action)
         ACT_ADV: begin
            go    = stat.vec_go;
            go_op = WALK_VEC;
         end
         ACT_TICK: begin
            go    = 1'b1;
            go_op = WALK_TICK;
         end
         ACT_READ: go = 1'b0;
         ACT_INIT: begin
            go    = 1'b1;
            go_op = WALK_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         op_ff    <= WALK_INIT;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && go) begin
                  state_ff <= ST_WALK;
                  cnt_ff   <= '0;
                  op_ff    <= go_op;
               end
            end
            ST_WALK: begin
               cnt_ff <= cnt_ff + ROW_W'(1);
               if (cnt_ff == ROW_W'(MAX_NODES - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd.accept   = accept;
      cmd.step_en  = (state_ff == ST_WALK);
      cmd.step_idx = cnt_ff;
      cmd.step_op  = op_ff;
      cmd.finish   = (state_ff == ST_DRAIN);
   end

endmodule

// ===== hdl/dvtu_dp.sv =====
`timescale 1ns / 1ps
module dvtu_dp (
   input  logic               clock,
   input  logic               reset,
   input  dvtu_pkg::cfg_type  cfg,
   input  dvtu_pkg::req_type  req_data,
   input  dvtu_pkg::cmd_type  cmd,
   output dvtu_pkg::stat_type stat,
   output logic               rsp_valid,
   output dvtu_pkg::rsp_type  rsp_data
);
   import dvtu_pkg::*;

   // routing table rows
   hop_type           hop_ff  [MAX_NODES];
   hop_type           hop_in  [MAX_NODES];
   logic [COST_W-1:0] cost_ff [MAX_NODES];
   logic [COST_W-1:0] cost_in [MAX_NODES];
   logic [TTL_W-1:0]  ttl_ff  [MAX_NODES];
   logic [TTL_W-1:0]  ttl_in  [MAX_NODES];

   // received vector buffer
   logic [COST_W-1:0] rc_mem [MAX_NODES];
   logic [COST_W-1:0] rc_rd_ff;

   logic              seen_v_ff;
   logic [ROW_W-1:0]  seen_idx_ff;
   logic [ROW_W-1:0]  sender_ff;
   logic              changed_ff;

   // row stage
   logic              proc_v_ff;
   logic [ROW_W-1:0]  proc_idx_ff;
   walk_op_type       proc_op_ff;

   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic              is_adv;
   logic              sel_cand;
   logic              seen_take;
   logic              nxt_seen_v;
   logic [ROW_W-1:0]  nxt_seen_idx;
   logic              vec_go;
   logic              vec_empty;

   logic [ROW_W-1:0]  kp;
   hop_type           hop_k;
   logic [COST_W-1:0] cost_k;
   logic [TTL_W-1:0]  ttl_k;
   logic              row_in;
   logic              row_nbr;
   logic              via_nbr;
   logic              row_relax;
   logic [COST_W:0]   cand;
   logic              improve;
   logic [COST_W-1:0] init_cost;
   logic [TTL_W-1:0]  aged_ttl;

   // sender pick: highest zero-cost entry inside the table
   always_comb begin
      is_adv       = (req_data.action == ACT_ADV);
      sel_cand     = (req_data.adv_cost == '0) &&
                     ({1'b0, req_data.node} < cfg.eff_count);
      seen_take    = sel_cand && (!seen_v_ff || req_data.node >= seen_idx_ff);
      nxt_seen_v   = seen_v_ff || sel_cand;
      nxt_seen_idx = seen_take ? req_data.node[ROW_W-1:0] : seen_idx_ff;
      vec_go       = cmd.accept && is_adv && req_data.last && nxt_seen_v;
      vec_empty    = cmd.accept && is_adv && req_data.last && !nxt_seen_v;
      stat.vec_go  = is_adv && req_data.last && nxt_seen_v;
   end

   always_comb begin
      kp        = proc_idx_ff;
      hop_k     = hop_ff[kp];
      cost_k    = cost_ff[kp];
      ttl_k     = ttl_ff[kp];
      row_in    = ({1'b0, kp} < cfg.eff_count);
      row_nbr   = cfg.neighbor_mask[kp];
      via_nbr   = row_nbr || (hop_k.valid && cfg.neighbor_mask[hop_k.idx]);
      row_relax = proc_v_ff && (proc_op_ff == WALK_VEC) && row_in &&
                  (kp != cfg.self_node) && (kp != sender_ff);
      cand      = {1'b0, rc_rd_ff} + (COST_W+1)'(1);
      improve   = row_relax && !via_nbr && ({1'b0, cost_k} > cand);
      if (kp == cfg.self_node) begin
         init_cost = '0;
      end else if (row_nbr) begin
         init_cost = COST_W'(1);
      end else begin
         init_cost = cfg.max_cost;
      end
      aged_ttl  = (ttl_k > cfg.tick_period) ? (ttl_k - cfg.tick_period) : '0;
   end

   always_comb begin
      hop_in  = hop_ff;
      cost_in = cost_ff;
      ttl_in  = ttl_ff;

      // sender row refreshed as the vector closes
      if (vec_go) begin
         cost_in[nxt_seen_idx] = COST_W'(1);
         hop_in[nxt_seen_idx]  = hop_type'{valid: 1'b1, idx: nxt_seen_idx};
         ttl_in[nxt_seen_idx]  = cfg.ttl_reload;
      end

      if (proc_v_ff) begin
         case (proc_op_ff)
            WALK_INIT: begin
               if (row_in) begin
                  cost_in[kp] = init_cost;
                  hop_in[kp]  = (init_cost >= cfg.max_cost) ? hop_type'('0) :
                                hop_type'{valid: 1'b1, idx: kp};
                  ttl_in[kp]  = cfg.ttl_reload;
               end else begin
                  cost_in[kp] = cfg.max_cost;
                  hop_in[kp]  = '0;
                  ttl_in[kp]  = '0;
               end
            end
            WALK_TICK: begin
               if (row_in && row_nbr) begin
                  if (ttl_k == '0) begin
                     // expired neighbour: poison it and every row in use routed through it
                     cost_in[kp] = cfg.max_cost;
                     hop_in[kp]  = '0;
                     for (int l = 0; l < MAX_NODES; l++) begin
                        if ((COUNT_W'(l) < cfg.eff_count) && hop_ff[l].valid &&
                            (hop_ff[l].idx == kp)) begin
                           cost_in[l] = cfg.max_cost;
                           hop_in[l]  = '0;
                        end
                     end
                  end else begin
                     ttl_in[kp] = aged_ttl;
                  end
               end
            end
            WALK_VEC: begin
               if (row_relax) begin
                  if (via_nbr) begin
                     if (cost_k == cfg.max_cost) begin
                        hop_in[kp] = '0;
                     end
                  end else if (improve) begin
                     cost_in[kp] = cand[COST_W-1:0];
                     hop_in[kp]  = hop_type'{valid: 1'b1, idx: sender_ff};
                     ttl_in[kp]  = cfg.ttl_reload;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_NODES; i++) begin
            hop_ff[i]  <= '0;
            cost_ff[i] <= '0;
            ttl_ff[i]  <= '0;
         end
      end else begin
         hop_ff  <= hop_in;
         cost_ff <= cost_in;
         ttl_ff  <= ttl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && is_adv) begin
         rc_mem[req_data.node[ROW_W-1:0]] <= req_data.adv_cost;
      end
      if (cmd.step_en) begin
         rc_rd_ff <= rc_mem[cmd.step_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_v_ff   <= 1'b0;
         seen_idx_ff <= '0;
         sender_ff   <= '0;
         changed_ff  <= 1'b0;
         proc_v_ff   <= 1'b0;
         proc_idx_ff <= '0;
         proc_op_ff  <= WALK_INIT;
      end else begin
         proc_v_ff   <= cmd.step_en;
         proc_idx_ff <= cmd.step_idx;
         proc_op_ff  <= cmd.step_op;
         if (cmd.accept && is_adv) begin
            seen_v_ff   <= req_data.last ? 1'b0 : nxt_seen_v;
            seen_idx_ff <= req_data.last ? '0 : nxt_seen_idx;
         end else if (cmd.accept && req_data.action == ACT_INIT) begin
            seen_v_ff   <= 1'b0;
            seen_idx_ff <= '0;
         end
         if (vec_go) begin
            sender_ff  <= nxt_seen_idx;
            changed_ff <= 1'b0;
         end else if (improve) begin
            changed_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.accept && req_data.action == ACT_READ) || vec_empty ||
                         (cmd.finish && proc_op_ff == WALK_VEC);
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.accept && req_data.action == ACT_READ) begin
         rsp_in            = '0;
         rsp_in.hop_valid  = hop_ff[req_data.node[ROW_W-1:0]].valid;
         rsp_in.hop_node   = hop_ff[req_data.node[ROW_W-1:0]].valid ?
                             NODE_W'(hop_ff[req_data.node[ROW_W-1:0]].idx) : '0;
         rsp_in.route_cost = cost_ff[req_data.node[ROW_W-1:0]];
         rsp_in.route_ttl  = ttl_ff[req_data.node[ROW_W-1:0]];
      end else if (vec_empty) begin
         rsp_in        = '0;
         rsp_in.status = 1'b1;
      end else if (cmd.finish) begin
         rsp_in         = '0;
         rsp_in.changed = changed_ff || improve;
         rsp_in.sender  = NODE_W'(sender_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_ff <= '0;
      end else begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/distance_vector_table_update_top.sv =====
// distance-vector routing table: one row per node holding next hop, cost and remaining
// lifetime. a read, or an advertisement entry that does not close its vector, is taken
// while busy is low, and a read answers on the result port in the next cycle.
// a tick, an init, and the last entry of a vector walk the table through a single row-update
// stage, one row per cycle over all 16 rows, then a drain state for the buffered-cost read;
// the vector's result strobes in the first cycle busy is low again, and a new beat can be
// taken that same cycle. a vector with no zero-cost sender entry inside the table answers
// with status set and starts no walk.
// rsp_valid is high for exactly one cycle per result and the receiver cannot stall it, so
// whatever consumes results must take every beat as it comes. configuration writes are
// always ready and must only be issued while the block is idle.
`timescale 1ns / 1ps
module distance_vector_table_update_top (
   input  logic                           clock,
   input  logic                           reset,
   // command channel
   input  logic                           start,
   output logic                           busy,
   input  dvtu_pkg::req_type              req_data,
   // result strobe
   output logic                           rsp_valid,
   output dvtu_pkg::rsp_type              rsp_data,
   // register writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dvtu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dvtu_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import dvtu_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   // configuration registers, effective row count derived here
   dvtu_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: accepts beats and steps the row walk
   dvtu_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   // table rows, vector buffer and result register
   dvtu_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/dvtu_checker.sv =====
`timescale 1ns / 1ps
module dvtu_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input dvtu_pkg::req_type              req_data,
   input logic                           rsp_valid,
   input dvtu_pkg::rsp_type              rsp_data,
   input logic                           csr_valid,
   input logic                           csr_ready
);
   import dvtu_pkg::*;

   logic acc;
   assign acc = start && !busy;

   // a read answers in the next cycle
   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      (acc && req_data.action == ACT_READ) |=> rsp_valid)
      else $error("read beat without result");

   // a tick always walks the table
   a_tick_walks: assert property (@(posedge clock) disable iff (reset)
      (acc && req_data.action == ACT_TICK) |=> busy)
      else $error("tick did not start a walk");

   // an entry that does not close its vector gives no result
   a_entry_quiet: assert property (@(posedge clock) disable iff (reset)
      (acc && req_data.action == ACT_ADV && !req_data.last) |=> !rsp_valid)
      else $error("result after a non-final entry");

   // an ignored vector carries no sender and no change
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (rsp_data.sender == '0 && !rsp_data.changed
                                          && !rsp_data.hop_valid))
      else $error("ignored vector with payload");

   // registers only change while no walk is running
   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |-> !busy)
      else $error("register write during a walk");

endmodule

bind distance_vector_table_update_top dvtu_checker u_dvtu_checker (.*);
